/* design/wdrc_pkg.sv */
package wdrc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 3;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KNEE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET  = 3'd6;

    // cubic log2 fit on the Q0.16 mantissa, Horner order
    localparam logic signed [23:0] LOG_C0 = 24'sd80707;
    localparam logic signed [23:0] LOG_C1 = -24'sd269912;
    localparam logic signed [23:0] LOG_C2 = 24'sd394656;
    localparam logic signed [23:0] LOG_C3 = -24'sd205387;

    // 2^f Taylor terms in Q24, Horner order
    localparam logic [25:0] EXP_C0 = 26'd2584;
    localparam logic [25:0] EXP_C1 = 26'd22370;
    localparam logic [25:0] EXP_C2 = 26'd161365;
    localparam logic [25:0] EXP_C3 = 26'd931204;
    localparam logic [25:0] EXP_C4 = 26'd4030332;
    localparam logic [25:0] EXP_C5 = 26'd11629080;
    localparam logic [25:0] EXP_ONE = 26'd16777216;

    localparam logic signed [26:0] DB_PER_OCTAVE_Q16 = 27'sd394566;
    localparam logic signed [26:0] OCTAVE_PER_DB_Q16 = 27'sd10885;

    // ceil(2^25/10): (n * this) >> 25 is floor(n/10) for n below 2^22
    localparam logic signed [26:0] DIV10_RECIP_Q25 = 27'sd3355444;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic                          stage_select;
        logic                          last_of_block;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic signed [15:0]            applied_gain_db;
        logic                          last_out;
    } out_item_t;

endpackage

/* design/wdrc_compressor_with_limiter.sv */
// Sequencing: from accept to result an item goes through one-bit-per-cycle normalization,
//   one or two bit-serial divisions by the ratio, and the steps of the single shared 34x27
//   multiplier (envelope, log2, curve, exponent); any output stall comes on top.
// Items: s_ready is high only while the sequencer is idle; no new item is taken before the
//   last is done. A finished result waits in the output register while the next is taken.
// Reset: synchronous, active low; clears envelopes, config registers to defaults, handshakes.
module wdrc_compressor_with_limiter
    import wdrc_pkg::*;
#(
    parameter int STAGE_COUNT = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int ST_W  = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int M_W   = $clog2(SB);
    localparam int DIV_W = 36;
    localparam int DC_W  = $clog2(DIV_W);

    typedef enum logic [4:0] {
        S_IDLE, S_ENV0, S_ENV1, S_ENV2, S_ENV3, S_NORM, S_LOG, S_LOGA, S_LOGE,
        S_LVL, S_DIV, S_GO, S_PB0, S_PB1, S_LDV, S_LIM, S_CMP, S_EXP0, S_EXP1,
        S_EXPM, S_EXPA, S_MAG, S_RND, S_OUT
    } state_t;

    state_t state_reg, div_ret_reg;

    // config
    logic [15:0]        attack_reg, release_reg, ratio_reg;
    logic signed [15:0] gain_reg, knee_reg, limit_reg, offset_reg;

    // envelope per stage
    logic [STAGE_COUNT-1:0][SB-1:0] env_reg;

    // item and datapath
    logic signed [SB-1:0] x_reg;
    logic [SB-1:0]        mag_reg;
    logic [ST_W-1:0]      st_reg;
    logic                 last_reg, att_reg;
    logic [SB+16:0]       acc_reg;
    logic [SB-1:0]        nrm_reg;
    logic [M_W-1:0]       m_reg;
    logic signed [5:0]    e_reg;
    logic [15:0]          f_reg;
    logic signed [23:0]   y_reg;
    logic [2:0]           idx_reg;
    logic signed [19:0]   lvl_reg;
    logic signed [17:0]   tk_reg;
    logic signed [25:0]   go_reg;
    logic [20:0]          lnum_reg;
    logic signed [15:0]   gdb_reg;
    logic [5:0]           sh_reg;
    logic [23:0]          fx_reg;
    logic [25:0]          p_reg;
    logic signed [SB-1:0] res_reg;
    logic signed [60:0]   prod_reg;

    // bit-serial divider
    logic [DIV_W-1:0]     div_quo_reg;
    logic [16:0]          div_rem_reg, div_den_reg;
    logic                 div_neg_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic signed [DIV_W-1:0] q_reg;

    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
        if (v > 38'sd32767)       return 16'sh7fff;
        else if (v < -38'sd32768) return 16'sh8000;
        else                      return 16'(v);
    endfunction

    // ---------------- combinational helpers ----------------
    logic [ST_W-1:0]      st_sel;
    logic [SB-1:0]        mag_in, env_cur;
    logic [16:0]          r_eff;
    logic signed [17:0]   tk_sum, tk_clamp;
    logic signed [33:0]   y_full;
    logic signed [33:0]   mul_a;
    logic signed [26:0]   mul_b;
    logic signed [60:0]   mul_p;
    logic signed [23:0]   log_c;
    logic [25:0]          exp_c;
    logic signed [30:0]   t_val;
    logic signed [34:0]   lim_dif;
    logic [60:0]          rnd_sum, q_mag;
    logic [17:0]          rem_sh;
    logic                 div_ge;
    logic [16:0]          rem_next;
    logic [DIV_W-1:0]     quo_next;
    logic signed [SB-1:0] res_next;
    logic [M_W-1:0]       m_next;
    logic signed [5:0]    e_next;

    always_comb begin
        if (STAGE_COUNT > 1 && 32'(s_data.stage_select) < STAGE_COUNT)
            st_sel = ST_W'(s_data.stage_select);
        else
            st_sel = ST_W'(STAGE_COUNT - 1);
    end

    assign mag_in  = s_data.in_sample[SB-1] ? SB'(-s_data.in_sample) : SB'(s_data.in_sample);
    assign env_cur = env_reg[st_reg];
    assign r_eff   = (ratio_reg == 16'd0) ? 17'd1 : {1'b0, ratio_reg};
    assign tk_sum  = 18'(gain_reg) + 18'(knee_reg);
    assign tk_clamp = (tk_sum > 18'(limit_reg)) ? 18'(limit_reg) - 18'(gain_reg)
                                                : 18'(knee_reg);
    assign y_full  = 34'(y_reg) + (34'(e_reg) <<< 16);
    assign m_next  = m_reg - M_W'(1);
    assign e_next  = 6'(m_reg) + 6'd2 - 6'(SB);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ENV0: begin
                mul_a = $signed(34'(env_cur));
                mul_b = (mag_reg >= env_cur) ? $signed(27'(attack_reg))
                                             : $signed(27'(release_reg));
            end
            S_ENV1: begin
                mul_a = $signed(34'(mag_reg));
                mul_b = $signed(27'(17'h10000 - {1'b0, attack_reg}));
            end
            S_LOG: begin
                mul_a = 34'(y_reg);
                mul_b = $signed(27'(f_reg));
            end
            S_LOGE: begin
                mul_a = y_full;
                mul_b = DB_PER_OCTAVE_Q16;
            end
            S_PB0: begin
                mul_a = 34'(limit_reg) - 34'(go_reg);
                mul_b = $signed(27'(r_eff));
            end
            S_LDV: begin
                // divide by 10 as a reciprocal multiply
                mul_a = $signed(34'(lnum_reg));
                mul_b = DIV10_RECIP_Q25;
            end
            S_EXP0: begin
                mul_a = 34'(gdb_reg);
                mul_b = OCTAVE_PER_DB_Q16;
            end
            S_EXPM: begin
                mul_a = $signed(34'(p_reg));
                mul_b = $signed(27'(fx_reg));
            end
            S_MAG: begin
                mul_a = $signed(34'(mag_reg));
                mul_b = $signed(27'(p_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (idx_reg)
            3'd0:    log_c = LOG_C1;
            3'd1:    log_c = LOG_C2;
            default: log_c = LOG_C3;
        endcase
        unique case (idx_reg)
            3'd0:    exp_c = EXP_C1;
            3'd1:    exp_c = EXP_C2;
            3'd2:    exp_c = EXP_C3;
            3'd3:    exp_c = EXP_C4;
            3'd4:    exp_c = EXP_C5;
            default: exp_c = EXP_ONE;
        endcase
    end

    assign t_val = 31'(prod_reg) + (31'sd32 <<< 24);

    // level above the limiter knee point, valid while prod_reg holds r*(limit-go)
    assign lim_dif = 35'(lvl_reg) - 35'(prod_reg >>> 8);

    // divider step: restoring, one quotient bit per cycle
    assign rem_sh   = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_next = div_ge ? 17'(rem_sh - {1'b0, div_den_reg}) : 17'(rem_sh);
    assign quo_next = {div_quo_reg[DIV_W-2:0], div_ge};

    // round half away from zero on the magnitude, then saturate
    always_comb begin
        rnd_sum = $unsigned(prod_reg) + (61'd1 << (sh_reg - 6'd1));
        q_mag   = rnd_sum >> sh_reg;
        if (!x_reg[SB-1]) begin
            if (q_mag > 61'((64'd1 << (SB - 1)) - 64'd1))
                res_next = {1'b0, {(SB-1){1'b1}}};
            else
                res_next = SB'(q_mag);
        end else begin
            if (q_mag > 61'(64'd1 << (SB - 1)))
                res_next = {1'b1, {(SB-1){1'b0}}};
            else
                res_next = SB'(~q_mag + 61'd1);
        end
    end

    // ---------------- sequencer ----------------
    task automatic div_start(input logic signed [DIV_W-1:0] num, input logic [16:0] den,
                             input state_t ret);
        div_neg_reg <= num[DIV_W-1];
        div_quo_reg <= num[DIV_W-1] ? ~num : num;
        div_rem_reg <= '0;
        div_den_reg <= den;
        div_cnt_reg <= '0;
        div_ret_reg <= ret;
        state_reg   <= S_DIV;
    endtask

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            env_reg     <= '0;
            attack_reg  <= 16'd0;
            release_reg <= 16'd0;
            gain_reg    <= 16'sd0;
            knee_reg    <= 16'sd12800;
            ratio_reg   <= 16'd256;
            limit_reg   <= 16'sd25600;
            offset_reg  <= 16'sd30464;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_ATTACK:  attack_reg  <= cfg_wdata;
                    REG_RELEASE: release_reg <= cfg_wdata;
                    REG_GAIN:    gain_reg    <= $signed(cfg_wdata);
                    REG_KNEE:    knee_reg    <= $signed(cfg_wdata);
                    REG_RATIO:   ratio_reg   <= cfg_wdata;
                    REG_LIMIT:   limit_reg   <= $signed(cfg_wdata);
                    REG_OFFSET:  offset_reg  <= $signed(cfg_wdata);
                    default: ;
                endcase
            end

            // S_OUT reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg    <= s_data.in_sample;
                        mag_reg  <= mag_in;
                        st_reg   <= st_sel;
                        last_reg <= s_data.last_of_block;
                        state_reg <= S_ENV0;
                    end
                end
                S_ENV0: begin
                    att_reg   <= (mag_reg >= env_cur);
                    state_reg <= S_ENV1;
                end
                S_ENV1: begin
                    acc_reg   <= prod_reg[SB+16:0];
                    state_reg <= att_reg ? S_ENV2 : S_ENV3;
                end
                S_ENV2: begin
                    // attack adds the (1-a)*|x| term
                    acc_reg   <= acc_reg + prod_reg[SB+16:0];
                    state_reg <= S_ENV3;
                end
                S_ENV3: begin
                    env_reg[st_reg] <= acc_reg[SB+15:16];
                    nrm_reg   <= acc_reg[SB+15:16];
                    m_reg     <= M_W'(SB - 1);
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    // zero envelope takes mantissa 0, exponent 0
                    y_reg   <= LOG_C0;
                    idx_reg <= 3'd0;
                    if (nrm_reg == '0) begin
                        f_reg     <= 16'd0;
                        e_reg     <= 6'sd0;
                        state_reg <= S_LOG;
                    end else if (nrm_reg[SB-1]) begin
                        f_reg     <= nrm_reg[SB-1 -: 16];
                        e_reg     <= e_next;
                        state_reg <= S_LOG;
                    end else begin
                        nrm_reg <= nrm_reg << 1;
                        m_reg   <= m_next;
                    end
                end
                S_LOG: state_reg <= S_LOGA;
                S_LOGA: begin
                    y_reg   <= 24'(prod_reg >>> 16) + log_c;
                    idx_reg <= idx_reg + 3'd1;
                    state_reg <= (idx_reg == 3'd2) ? S_LOGE : S_LOG;
                end
                S_LOGE: state_reg <= S_LVL;
                S_LVL: begin
                    lvl_reg <= 20'(offset_reg) + 20'(prod_reg >>> 24);
                    tk_reg  <= tk_clamp;
                    div_start(DIV_W'(tk_clamp) <<< 8, r_eff, S_GO);
                end
                S_DIV: begin
                    div_quo_reg <= quo_next;
                    div_rem_reg <= rem_next;
                    div_cnt_reg <= div_cnt_reg + DC_W'(1);
                    if (div_cnt_reg == DC_W'(DIV_W - 1)) begin
                        // floor for negative numerators via one's complement
                        q_reg     <= div_neg_reg ? $signed(~quo_next) : $signed(quo_next);
                        state_reg <= div_ret_reg;
                    end
                end
                S_GO: begin
                    go_reg    <= 26'(gain_reg) + 26'(tk_reg) - 26'(q_reg);
                    state_reg <= S_PB0;
                end
                S_PB0: state_reg <= S_PB1;
                S_PB1: begin
                    priority if (lvl_reg < 20'(tk_reg) && r_eff >= 17'd256) begin
                        gdb_reg   <= gain_reg;
                        state_reg <= S_EXP0;
                    end else if (34'(lvl_reg) > 34'(prod_reg >>> 8)) begin
                        // past 2^21 the limiter gain saturates either way
                        lnum_reg  <= (lim_dif > 35'sd2097151) ? 21'h1fffff : 21'(lim_dif);
                        state_reg <= S_LDV;
                    end else begin
                        div_start(DIV_W'(lvl_reg) <<< 8, r_eff, S_CMP);
                    end
                end
                S_LDV: state_reg <= S_LIM;
                S_LIM: begin
                    gdb_reg   <= sat16(38'(limit_reg) + 38'(prod_reg >>> 25) - 38'(lvl_reg));
                    state_reg <= S_EXP0;
                end
                S_CMP: begin
                    gdb_reg   <= sat16(38'(q_reg) - 38'(lvl_reg) + 38'(go_reg));
                    state_reg <= S_EXP0;
                end
                S_EXP0: state_reg <= S_EXP1;
                S_EXP1: begin
                    // integer octave offset by 32 keeps t positive
                    sh_reg    <= 6'd56 - 6'(t_val[29:24]);
                    fx_reg    <= t_val[23:0];
                    p_reg     <= EXP_C0;
                    idx_reg   <= 3'd0;
                    state_reg <= S_EXPM;
                end
                S_EXPM: state_reg <= S_EXPA;
                S_EXPA: begin
                    p_reg     <= 26'(prod_reg >>> 24) + exp_c;
                    idx_reg   <= idx_reg + 3'd1;
                    state_reg <= (idx_reg == 3'd5) ? S_MAG : S_EXPM;
                end
                S_MAG: state_reg <= S_RND;
                S_RND: begin
                    res_reg   <= res_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_sample      <= res_reg;
                        m_data_reg.applied_gain_db <= gdb_reg;
                        m_data_reg.last_out        <= last_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block still ready after taking an item");

    a_env_write_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ENV3) |=> $stable(env_reg))
        else $error("envelope changed outside its update step");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (32'(div_cnt_reg) < DIV_W))
        else $error("divider ran past its bit count");

    a_out_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_data_reg.last_out == last_reg))
        else $error("framing mark lost on result");

endmodule

/* verif/tb_wdrc_compressor_with_limiter.sv */
module tb_wdrc_compressor_with_limiter;
    import wdrc_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    always #6 aclk = ~aclk;

    wdrc_compressor_with_limiter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Local copy of the block state: registers and per-stage peak envelope
    // ------------------------------------------------------------------
    logic [15:0] attack_q16, release_q16, ratio_q8;
    logic signed [15:0] gain_db, knee_db, limit_db, offset_db;
    longint      peak_env [2];

    in_item_t  sample_queue [$];   // items waiting for the driver
    out_item_t expected_out [$];   // predicted results, oldest first

    int  errors      = 0;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  n_settings  = 0;
    bit  calm        = 1'b0;       // no idling on either side in the final part

    // floor division, signed
    function automatic longint fdiv(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-(n + 1)) / d) - 1;
    endfunction

    // envelope magnitude -> dB Q8.8, without the full-scale offset
    function automatic longint peak_to_db(longint pk);
        longint f, e, y;
        int     m;
        f = 0;
        e = 0;
        m = 0;
        if (pk != 0) begin
            while (m < 62 && (pk >> (m + 1)) != 0) m++;
            f = (m >= 15) ? (pk >> (m - 15)) : (pk << (15 - m));
            e = m + 2 - SAMPLE_BITS;
        end
        // Horner on the mantissa, every product floored back to Q16
        y = LOG_C0;
        y = ((y * f) >>> 16) + LOG_C1;
        y = ((y * f) >>> 16) + LOG_C2;
        y = ((y * f) >>> 16) + LOG_C3;
        y = y + e * 65536;
        return (y * DB_PER_OCTAVE_Q16) >>> 24;
    endfunction

    // sample * 10^(gain/20), rounded half away from zero, saturated
    function automatic longint scale_sample(longint x, longint g);
        longint t, ip, f, p, mag, q;
        int     sh;
        t   = g * OCTAVE_PER_DB_Q16 + (longint'(32) << 24);
        ip  = (t >>> 24) - 32;
        f   = t & 64'hFFFFFF;
        p   = EXP_C0;
        p   = ((p * f) >> 24) + EXP_C1;
        p   = ((p * f) >> 24) + EXP_C2;
        p   = ((p * f) >> 24) + EXP_C3;
        p   = ((p * f) >> 24) + EXP_C4;
        p   = ((p * f) >> 24) + EXP_C5;
        p   = ((p * f) >> 24) + EXP_ONE;
        mag = (x < 0) ? -x : x;
        sh  = 24 - int'(ip);
        if (sh < 1) sh = 1;
        q = (sh > 62) ? 0 : ((mag * p + (longint'(1) << (sh - 1))) >> sh);
        if (x >= 0) return (q > 8388607) ? 8388607 : q;
        if (q > 8388608) q = 8388608;
        return -q;
    endfunction

    // one item through envelope, level, gain curve and gain stage
    function automatic out_item_t compress_sample(in_item_t it);
        out_item_t res;
        longint x, xab, pk, lvl, g, tk, bolt, r, go, pb, gdb;
        int     st;
        st  = int'(it.stage_select);
        x   = longint'(it.in_sample);
        xab = (x < 0) ? -x : x;
        pk  = peak_env[st];
        if (xab >= pk)
            pk = (longint'(attack_q16) * pk + (65536 - longint'(attack_q16)) * xab) >> 16;
        else
            pk = (longint'(release_q16) * pk) >> 16;
        peak_env[st] = pk;

        lvl  = longint'(offset_db) + peak_to_db(pk);
        g    = gain_db;
        tk   = knee_db;
        bolt = limit_db;
        r    = (ratio_q8 == 0) ? 1 : longint'(ratio_q8);
        // knee clamped so that knee plus gain never passes the limiter
        if (tk + g > bolt) tk = bolt - g;
        go = g + tk - fdiv(tk * 256, r);
        pb = (r * (bolt - go)) >>> 8;
        if (lvl < tk && r >= 256)
            gdb = g;
        else if (lvl > pb)
            gdb = bolt + fdiv(lvl - pb, 10) - lvl;   // 10:1 limiter
        else
            gdb = fdiv(lvl * 256, r) - lvl + go;     // compressive region
        if (gdb > 32767)  gdb = 32767;
        if (gdb < -32768) gdb = -32768;

        res.out_sample      = SAMPLE_BITS'(scale_sample(x, gdb));
        res.applied_gain_db = 16'(gdb);
        res.last_out        = it.last_of_block;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds sample_queue into the input channel, with idle bursts.
    // Accepted items are predicted here, with pre-edge values.
    // ------------------------------------------------------------------
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_out.push_back(compress_sample(s_data));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        src_gap = $urandom_range(1, 7) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_data  <= sample_queue.pop_front();
                        s_valid <= 1'b1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction, and
    // stalls the result channel in bursts.
    // ------------------------------------------------------------------
    int snk_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected result out=%0d gain=%0d last=%0b", $time,
                             m_data.out_sample, m_data.applied_gain_db, m_data.last_out);
                    errors++;
                end else begin
                    out_item_t exp_r;
                    exp_r = expected_out.pop_front();
                    n_checked++;
                    if (m_data.out_sample !== exp_r.out_sample) begin
                        $display("%0t: out_sample expected %0d actual %0d", $time,
                                 exp_r.out_sample, m_data.out_sample);
                        errors++;
                    end
                    if (m_data.applied_gain_db !== exp_r.applied_gain_db) begin
                        $display("%0t: applied_gain_db expected %0d actual %0d", $time,
                                 exp_r.applied_gain_db, m_data.applied_gain_db);
                        errors++;
                    end
                    if (m_data.last_out !== exp_r.last_out) begin
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 exp_r.last_out, m_data.last_out);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // all seven registers, back to back, enable dropped once at the end
    task automatic load_regs(input logic [15:0] a, b, g, k, r, l, o);
        logic [15:0] vals [7];
        vals = '{a, b, g, k, r, l, o};
        for (int i = 0; i < 7; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= i[CFG_ADDR_W-1:0];
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attack_q16  = a;
        release_q16 = b;
        gain_db     = g;
        knee_db     = k;
        ratio_q8    = r;
        limit_db    = l;
        offset_db   = o;
        n_settings++;
    endtask

    task automatic queue_sample(input int x, input bit st, input bit last);
        in_item_t it;
        it.in_sample     = x[SAMPLE_BITS-1:0];
        it.stage_select  = st;
        it.last_of_block = last;
        sample_queue.push_back(it);
    endtask

    // block is idle: everything sent, everything predicted has come back
    task automatic drain();
        while (sample_queue.size() != 0 || s_valid || expected_out.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // audio-like run: loud/quiet passages so attack and release both act
    task automatic queue_audio(input int n);
        int  level, mag;
        bit  neg;
        level = $urandom_range(0, 23);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 23);
            case ($urandom_range(0, 19))
                0:       mag = 8388608;
                1:       mag = 0;
                2:       mag = $urandom_range(0, 8388607);
                default: mag = $urandom_range(0, (1 << level) - 1);
            endcase
            neg = $urandom_range(0, 1);
            if (mag == 8388608) neg = 1'b1;
            queue_sample(neg ? -mag : mag, $urandom_range(0, 1),
                         (i % 16 == 15) ^ ($urandom_range(0, 15) == 0));
        end
    endtask

    // register setting: mostly hearing-aid-like, sometimes anything at all
    task automatic pick_regs();
        if ($urandom_range(0, 3) == 0) begin
            load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            load_regs(16'(65535 - $urandom_range(0, 8000)),
                      16'(65535 - $urandom_range(0, 3000)),
                      16'(($urandom_range(0, 50) - 10) * 256 + $urandom_range(0, 255)),
                      16'($urandom_range(30, 80) * 256 + $urandom_range(0, 255)),
                      16'($urandom_range(128, 2560)),
                      16'($urandom_range(70, 115) * 256 + $urandom_range(0, 255)),
                      16'($urandom_range(95, 125) * 256 + $urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        attack_q16  = 16'd0;
        release_q16 = 16'd0;
        gain_db     = 16'sd0;
        knee_db     = 16'sd12800;
        ratio_q8    = 16'd256;
        limit_db    = 16'sd25600;
        offset_db   = 16'sd30464;
        peak_env    = '{0, 0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: instant attack, so a rising envelope takes the sample; release drops it to zero
        queue_sample(0, 0, 0);              // zero envelope on a fresh stage
        queue_sample(0, 1, 1);
        queue_sample(8388607, 0, 0);
        queue_sample(-8388608, 1, 1);
        queue_sample(1, 0, 0);
        queue_sample(-1, 1, 0);
        queue_sample(0, 0, 1);
        drain();

        // ratio zero, plus a knee that must be clamped under the limiter
        load_regs(16'd0, 16'd32768, 16'sd5120, 16'sd25600, 16'd0, 16'sd20480, 16'sd30464);
        queue_sample(4096, 0, 0);
        queue_sample(-8388608, 1, 1);
        queue_sample(0, 0, 0);
        drain();

        // ratio below one: constant-gain branch skipped below the knee
        load_regs(16'd0, 16'd65535, 16'sd2560, 16'sd12800, 16'd128, 16'sd25600, 16'sd30464);
        queue_sample(100, 0, 0);
        queue_sample(-2000000, 1, 1);
        queue_sample(0, 1, 0);
        drain();

        // gain beyond Q8.8 and output overflow: huge gain on a loud sample
        load_regs(16'd65535, 16'd0, 16'sd32767, 16'h8000, 16'd1, 16'sd32767, 16'h8000);
        queue_sample(8388607, 0, 0);
        queue_sample(-8388608, 1, 0);
        queue_sample(3, 0, 1);
        queue_sample(-5, 1, 0);
        drain();

        // all-zero and all-ones register extremes
        load_regs('0, '0, '0, '0, '0, '0, '0);
        queue_audio(12);
        drain();
        load_regs('1, '1, '1, '1, '1, '1, '1);
        queue_audio(12);
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 19; ph++) begin
            pick_regs();
            queue_audio(95);
            drain();
        end

        // final stretch at full rate on both sides
        calm = 1'b1;
        pick_regs();
        queue_audio(60);
        drain();
        repeat (150) @(posedge aclk);

        $display("Covered %0d items over %0d register settings, %0d results checked.",
                 n_accepted, n_settings, n_checked);
        if (errors == 0 && expected_out.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Timeout with %0d results outstanding.", expected_out.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/wdrc_pkg.sv
design/wdrc_compressor_with_limiter.sv
verif/tb_wdrc_compressor_with_limiter.sv
